// ===== hw/rtl/mbgb_pkg.sv =====
// Shared types and constants for the monochrome bitmap glyph blitter.
package mbgb_pkg;

    // Operation codes carried in the item's operation field
    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_SET       = 3'd1;
    localparam logic [2:0] OP_GET       = 3'd2;
    localparam logic [2:0] OP_INVERT    = 3'd3;
    localparam logic [2:0] OP_DRAW_CHAR = 3'd4;
    localparam logic [2:0] OP_LOAD_FONT = 3'd5;
    localparam logic [2:0] OP_READ_BYTE = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_BITMAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_BITMAP_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GLYPH_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_GLYPH_HEIGHT  = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_BITMAP_WIDTH  = 8'd16;
    localparam logic [7:0] RST_BITMAP_HEIGHT = 8'd8;
    localparam logic [4:0] RST_GLYPH_WIDTH   = 5'd5;
    localparam logic [4:0] RST_GLYPH_HEIGHT  = 5'd8;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_RB_READ,
        ST_GSIZE,
        ST_GBASE,
        ST_CALC,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch accepted item
        logic clr_step;  // zero one frame byte
        logic font_wr;   // glyph store write
        logic gsize;     // bytes per glyph, reset glyph counters
        logic gbase;     // glyph base address
        logic calc;      // target pixel coordinates and row product
        logic rd;        // read both stores
        logic wr;        // modify and write frame byte
        logic step;      // next glyph pixel
        logic push;      // load result register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic gsize_zero;
        logic glyph_last;
    } sts_t;

endpackage

// ===== hw/rtl/mbgb_item_if.sv =====
// Input item channel: valid/ready handshake with the operation payload.
interface mbgb_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        pixel_value;
    logic [7:0]  glyph_index;
    logic [12:0] font_address;
    logic [7:0]  font_byte;
    logic [8:0]  byte_address;

    modport source (
        output valid, operation, pos_x, pos_y, pixel_value, glyph_index,
               font_address, font_byte, byte_address,
        input  ready
    );

    modport sink (
        input  valid, operation, pos_x, pos_y, pixel_value, glyph_index,
               font_address, font_byte, byte_address,
        output ready
    );
endinterface

// ===== hw/rtl/mbgb_result_if.sv =====
// Result item channel: valid/ready handshake with the readout payload.
interface mbgb_result_if;
    logic       valid;
    logic       ready;
    logic       pixel_out;
    logic [7:0] byte_out;
    logic       ignored;

    modport source (
        output valid, pixel_out, byte_out, ignored,
        input  ready
    );

    modport sink (
        input  valid, pixel_out, byte_out, ignored,
        output ready
    );
endinterface

// ===== hw/rtl/mbgb_datapath.sv =====
// Datapath: configuration, frame and glyph memories, address arithmetic, result register.
module mbgb_datapath #(
    parameter int FRAME_BYTES = 512,
    parameter int FONT_BYTES  = 8192
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic [2:0]       operation,
    input  logic [7:0]       pos_x,
    input  logic [7:0]       pos_y,
    input  logic             pixel_value,
    input  logic [7:0]       glyph_index,
    input  logic [12:0]      font_address,
    input  logic [7:0]       font_byte,
    input  logic [8:0]       byte_address,
    input  mbgb_pkg::cmd_t   cmd,
    output mbgb_pkg::sts_t   sts,
    output logic             pixel_out,
    output logic [7:0]       byte_out,
    output logic             ignored
);
    import mbgb_pkg::*;

    localparam int FB_AW   = $clog2(FRAME_BYTES);
    localparam int FONT_AW = $clog2(FONT_BYTES);
    localparam logic [16:0] FRAME_LIM = 17'(FRAME_BYTES);
    localparam logic [16:0] FONT_LIM  = 17'(FONT_BYTES);
    localparam logic [FB_AW-1:0] CLR_LAST = FB_AW'(FRAME_BYTES - 1);

    // configuration
    logic [7:0] bw_reg, bh_reg;
    logic [4:0] gw_reg, gh_reg;

    // latched item
    logic [2:0]  op_reg;
    logic [7:0]  x_reg, y_reg, gidx_reg, fbyte_reg;
    logic        val_reg;
    logic [12:0] faddr_reg;
    logic [8:0]  baddr_reg;

    // glyph walk
    logic [4:0]  cx_reg, cy_reg;
    logic [9:0]  p_reg;
    logic [6:0]  gbytes_reg;
    logic [14:0] base_reg;

    // pixel address pipeline
    logic [8:0]  tx_reg;
    logic [16:0] prod_reg;
    logic        inb_reg;
    logic [15:0] ga_reg;
    logic [2:0]  gbit_reg;
    logic        ok_reg;
    logic [2:0]  pbit_reg;
    logic [FB_AW-1:0] waddr_reg;
    logic [7:0]  pix_rdata_reg, gly_rdata_reg;

    // result
    logic        res_pix_reg, res_ign_reg;
    logic        out_pix_reg, out_ign_reg;
    logic [7:0]  out_byte_reg;

    logic [FB_AW-1:0] clr_cnt_reg;

    logic [7:0] pix_mem [FRAME_BYTES];
    logic [7:0] gly_mem [FONT_BYTES];

    logic        is_draw;
    logic [8:0]  tx_next, ty_next;
    logic [17:0] off;
    logic [17:0] baddr_w;
    logic [16:0] faddr_w;
    logic        ok_next;
    logic [FB_AW-1:0] pix_raddr, pix_waddr;
    logic        pix_we;
    logic [7:0]  pix_wdata, mod_byte;
    logic        bit_val;
    logic [9:0]  gprod;
    logic [10:0] gprod_rnd;

    assign is_draw = (op_reg == OP_DRAW_CHAR);
    assign baddr_w = 18'(baddr_reg);
    assign faddr_w = 17'(faddr_reg);

    always_comb
    begin
        if (is_draw)
        begin
            tx_next = 9'(x_reg) + 9'(cx_reg);
            ty_next = 9'(y_reg) + 9'(cy_reg);
        end
        else
        begin
            tx_next = 9'(x_reg);
            ty_next = 9'(y_reg);
        end
    end

    assign off = 18'(tx_reg) + 18'(prod_reg);

    always_comb
    begin
        if (op_reg == OP_READ_BYTE)
        begin
            ok_next   = (17'(baddr_reg) < FRAME_LIM);
            pix_raddr = baddr_w[FB_AW-1:0];
        end
        else
        begin
            ok_next   = inb_reg && (17'(off[17:3]) < FRAME_LIM)
                        && (!is_draw || (17'(ga_reg) < FONT_LIM));
            pix_raddr = off[FB_AW+2:3];
        end
    end

    always_comb
    begin
        unique case (op_reg)
            OP_SET:       bit_val = val_reg;
            OP_INVERT:    bit_val = ~pix_rdata_reg[pbit_reg];
            OP_DRAW_CHAR: bit_val = gly_rdata_reg[3'd7 - gbit_reg];
            default:      bit_val = pix_rdata_reg[pbit_reg];
        endcase
        mod_byte = pix_rdata_reg;
        mod_byte[pbit_reg] = bit_val;
    end

    assign pix_we    = cmd.clr_step || (cmd.wr && ok_reg && (op_reg != OP_GET));
    assign pix_wdata = cmd.clr_step ? 8'd0 : mod_byte;
    assign pix_waddr = cmd.clr_step ? clr_cnt_reg : waddr_reg;

    assign gprod     = 10'(gw_reg) * 10'(gh_reg);
    assign gprod_rnd = 11'(gprod) + 11'd7;

    assign sts.clr_last   = (clr_cnt_reg == CLR_LAST);
    assign sts.gsize_zero = (gw_reg == 5'd0) || (gh_reg == 5'd0);
    assign sts.glyph_last = (cy_reg == gh_reg - 5'd1) && (cx_reg == gw_reg - 5'd1);

    // memories
    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (cmd.rd)
        begin
            pix_rdata_reg <= pix_mem[pix_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.font_wr && (faddr_w < FONT_LIM))
        begin
            gly_mem[faddr_w[FONT_AW-1:0]] <= fbyte_reg;
        end
        if (cmd.rd)
        begin
            gly_rdata_reg <= gly_mem[ga_reg[FONT_AW-1:0]];
        end
    end

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg      <= RST_BITMAP_WIDTH;
            bh_reg      <= RST_BITMAP_HEIGHT;
            gw_reg      <= RST_GLYPH_WIDTH;
            gh_reg      <= RST_GLYPH_HEIGHT;
            clr_cnt_reg <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            p_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BITMAP_WIDTH:  bw_reg <= cfg_data;
                    CFG_BITMAP_HEIGHT: bh_reg <= cfg_data;
                    CFG_GLYPH_WIDTH:   gw_reg <= cfg_data[4:0];
                    CFG_GLYPH_HEIGHT:  gh_reg <= cfg_data[4:0];
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + FB_AW'(1);
            end
            if (cmd.gsize)
            begin
                cx_reg <= '0;
                cy_reg <= '0;
                p_reg  <= '0;
            end
            else if (cmd.step)
            begin
                // column-major walk: cy inner, cx outer
                if (cy_reg == gh_reg - 5'd1)
                begin
                    cy_reg <= '0;
                    cx_reg <= cx_reg + 5'd1;
                    p_reg  <= 10'(cx_reg) + 10'd1;
                end
                else
                begin
                    cy_reg <= cy_reg + 5'd1;
                    p_reg  <= p_reg + 10'(gw_reg);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            x_reg       <= pos_x;
            y_reg       <= pos_y;
            val_reg     <= pixel_value;
            gidx_reg    <= glyph_index;
            faddr_reg   <= font_address;
            fbyte_reg   <= font_byte;
            baddr_reg   <= byte_address;
            res_pix_reg <= 1'b0;
            res_ign_reg <= (operation > OP_READ_BYTE);
        end
        if (cmd.font_wr && !(faddr_w < FONT_LIM))
        begin
            res_ign_reg <= 1'b1;
        end
        if (cmd.gsize)
        begin
            gbytes_reg <= gprod_rnd[9:3];
        end
        if (cmd.gbase)
        begin
            base_reg <= 15'(gidx_reg) * 15'(gbytes_reg);
        end
        if (cmd.calc)
        begin
            tx_reg   <= tx_next;
            prod_reg <= 17'(ty_next) * 17'(bw_reg);
            inb_reg  <= (tx_next < 9'(bw_reg)) && (ty_next < 9'(bh_reg));
            ga_reg   <= 16'(base_reg) + 16'(p_reg[9:3]);
            gbit_reg <= p_reg[2:0];
        end
        if (cmd.rd)
        begin
            ok_reg    <= ok_next;
            pbit_reg  <= off[2:0];
            waddr_reg <= off[FB_AW+2:3];
            if (!ok_next)
            begin
                res_ign_reg <= 1'b1;
            end
        end
        if (cmd.wr && ok_reg && (op_reg == OP_GET))
        begin
            res_pix_reg <= pix_rdata_reg[pbit_reg];
        end
        if (cmd.push)
        begin
            out_pix_reg  <= res_pix_reg;
            out_ign_reg  <= res_ign_reg;
            out_byte_reg <= ((op_reg == OP_READ_BYTE) && ok_reg) ? pix_rdata_reg : 8'd0;
        end
    end

    assign pixel_out = out_pix_reg;
    assign byte_out  = out_byte_reg;
    assign ignored   = out_ign_reg;

endmodule

// ===== hw/rtl/mbgb_ctrl.sv =====
// Controller: sequences each item through the datapath and owns the handshakes.
module mbgb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       in_op,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  mbgb_pkg::sts_t   sts,
    output mbgb_pkg::cmd_t   cmd
);
    import mbgb_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            op_reg        <= OP_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = in_op;
                    unique case (in_op)
                        OP_CLEAR:                    state_next = ST_CLEAR;
                        OP_SET, OP_GET, OP_INVERT:   state_next = ST_CALC;
                        OP_DRAW_CHAR:                state_next = ST_GSIZE;
                        OP_LOAD_FONT:                state_next = ST_LOAD;
                        OP_READ_BYTE:                state_next = ST_RB_READ;
                        default:                     state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                cmd.font_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_RB_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_DONE;
            end
            ST_GSIZE:
            begin
                cmd.gsize  = 1'b1;
                state_next = sts.gsize_zero ? ST_DONE : ST_GBASE;
            end
            ST_GBASE:
            begin
                cmd.gbase  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr = 1'b1;
                if ((op_reg == OP_DRAW_CHAR) && !sts.glyph_last)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_CALC;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still held");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> out_valid_reg)
        else $error("finished item not presented");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (!in_ready && !cmd.push && !cmd.wr))
        else $error("activity during frame clearing after reset");

endmodule

// ===== hw/rtl/mono_bitmap_glyph_blitter_top.sv =====
// Top level of the monochrome bitmap glyph blitter.
// One item at a time; a result register lets the next item enter while the
// previous result waits. Every pixel is a read-modify-write through the
// single write port of the frame memory, taking an address stage, a read
// stage and a write stage. After reset the frame memory is zeroed one byte
// per cycle, and no item is taken until that is done; configuration writes
// are taken throughout.
module mono_bitmap_glyph_blitter_top #(
    parameter int FRAME_BYTES = 512,
    parameter int FONT_BYTES  = 8192
) (
    input  logic         clk,
    input  logic         rst_n,
    mbgb_item_if.sink    item,
    mbgb_result_if.source result,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);
    import mbgb_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_ready;
    logic out_valid;

    mbgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_op     (item.operation),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mbgb_datapath #(
        .FRAME_BYTES (FRAME_BYTES),
        .FONT_BYTES  (FONT_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (item.operation),
        .pos_x        (item.pos_x),
        .pos_y        (item.pos_y),
        .pixel_value  (item.pixel_value),
        .glyph_index  (item.glyph_index),
        .font_address (item.font_address),
        .font_byte    (item.font_byte),
        .byte_address (item.byte_address),
        .cmd          (cmd),
        .sts          (sts),
        .pixel_out    (result.pixel_out),
        .byte_out     (result.byte_out),
        .ignored      (result.ignored)
    );

    assign item.ready   = in_ready;
    assign result.valid = out_valid;

endmodule

// ===== dv/mono_bitmap_glyph_blitter_top_tb.sv =====
// Testbench for the bitmap glyph blitter: directed table, then random phases over many settings.
`timescale 1ns / 1ps

module mono_bitmap_glyph_blitter_top_tb;
    import mbgb_pkg::*;

    localparam int FRAME_BYTES = 512;
    localparam int FONT_BYTES  = 8192;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [2:0] PIXEL_OPS [4] = '{OP_SET, OP_GET, OP_INVERT, OP_READ_BYTE};

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic        pixel_value;
        logic [7:0]  glyph_index;
        logic [12:0] font_address;
        logic [7:0]  font_byte;
        logic [8:0]  byte_address;
    } blit_cmd_t;

    typedef struct packed {
        logic       pixel_out;
        logic [7:0] byte_out;
        logic       ignored;
    } readout_t;

    typedef struct packed {
        blit_cmd_t cmd;
        logic      typed;
        readout_t  want;
    } stim_t;

    // addr feeds both font_address and byte_address
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        val;
        logic [7:0]  gidx;
        logic [12:0] addr;
        logic [7:0]  data;
        logic        typed;
        logic        want_pix;
        logic [7:0]  want_byte;
        logic        want_ign;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    mbgb_item_if   item_ch ();
    mbgb_result_if result_ch ();

    mono_bitmap_glyph_blitter_top #(
        .FRAME_BYTES (FRAME_BYTES),
        .FONT_BYTES  (FONT_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Predicted block state
    logic [7:0] frame_mem [FRAME_BYTES];
    logic [7:0] font_mem [FONT_BYTES];
    int frame_w = RST_BITMAP_WIDTH;
    int frame_h = RST_BITMAP_HEIGHT;
    int glyph_w = RST_GLYPH_WIDTH;
    int glyph_h = RST_GLYPH_HEIGHT;

    // Font bytes already queued for loading; draws only touch loaded glyphs
    bit glyph_loaded [FONT_BYTES];

    stim_t    cmd_queue [$];
    readout_t pending_readouts [$];
    bit       sending = 1'b0;
    bit       steady = 1'b0;
    int       hold_request = 0;

    int n_items = 0;
    int n_draws = 0;
    int n_flagged = 0;
    int n_checked = 0;
    int n_settings = 0;
    int n_errors = 0;

    stim_row_t directed_rows [26];

    function automatic logic frame_locate(input int px, input int py,
                                          output int byte_ix, output int bit_ix);
        int offset;
        byte_ix = 0;
        bit_ix = 0;
        if (px >= frame_w || py >= frame_h)
            return 1'b0;
        offset = px + py * frame_w;
        if ((offset >> 3) >= FRAME_BYTES)
            return 1'b0;
        byte_ix = offset >> 3;
        bit_ix = offset & 7;
        return 1'b1;
    endfunction

    function automatic readout_t predict_readout(input blit_cmd_t c);
        readout_t r;
        int bi;
        int bn;
        int per;
        int base;
        int p;
        int ga;
        r = '0;
        case (c.operation)
            OP_CLEAR:
                for (int i = 0; i < FRAME_BYTES; i++)
                    frame_mem[i] = 8'h00;
            OP_SET:
                if (frame_locate(c.pos_x, c.pos_y, bi, bn))
                    frame_mem[bi][bn] = c.pixel_value;
                else
                    r.ignored = 1'b1;
            OP_GET:
                if (frame_locate(c.pos_x, c.pos_y, bi, bn))
                    r.pixel_out = frame_mem[bi][bn];
                else
                    r.ignored = 1'b1;
            OP_INVERT:
                if (frame_locate(c.pos_x, c.pos_y, bi, bn))
                    frame_mem[bi][bn] = ~frame_mem[bi][bn];
                else
                    r.ignored = 1'b1;
            OP_DRAW_CHAR:
            begin
                per = (glyph_w * glyph_h + 7) / 8;
                base = c.glyph_index * per;
                for (int cx = 0; cx < glyph_w; cx++)
                begin
                    for (int cy = 0; cy < glyph_h; cy++)
                    begin
                        p = cx + cy * glyph_w;
                        ga = base + (p >> 3);
                        if (!frame_locate(c.pos_x + cx, c.pos_y + cy, bi, bn) ||
                            ga >= FONT_BYTES)
                            r.ignored = 1'b1;
                        else
                            frame_mem[bi][bn] = font_mem[ga][7 - (p & 7)];  // MSB-first
                    end
                end
            end
            OP_LOAD_FONT:
                if (c.font_address < FONT_BYTES)
                    font_mem[c.font_address] = c.font_byte;
                else
                    r.ignored = 1'b1;
            OP_READ_BYTE:
                if (c.byte_address < FRAME_BYTES)
                    r.byte_out = frame_mem[c.byte_address];
                else
                    r.ignored = 1'b1;
            default:
                r.ignored = 1'b1;
        endcase
        return r;
    endfunction

    function automatic blit_cmd_t random_cmd(input logic [2:0] op);
        blit_cmd_t c;
        c.operation    = op;
        c.pos_x        = 8'($urandom);
        c.pos_y        = 8'($urandom);
        c.pixel_value  = 1'($urandom);
        c.glyph_index  = 8'($urandom);
        c.font_address = 13'($urandom);
        c.font_byte    = 8'($urandom);
        c.byte_address = 9'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] pick_x();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, frame_w - 1));
        return 8'($urandom);
    endfunction

    // Rows that still fit in the frame store, so wide bitmaps get real hits
    function automatic logic [7:0] pick_y();
        int rows;
        rows = (FRAME_BYTES * 8 - 1) / frame_w;
        if (rows > frame_h - 1)
            rows = frame_h - 1;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, rows));
        return 8'($urandom);
    endfunction

    function automatic logic [8:0] pick_byte_addr();
        int used;
        used = (frame_w * frame_h + 7) / 8;
        if (used > FRAME_BYTES)
            used = FRAME_BYTES;
        if ($urandom_range(0, 1) != 0)
            return 9'($urandom_range(0, used - 1));
        return 9'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 40)
            $display("ERROR: readout %0d: %s is %0h, expected %0h", n_checked, what, got, want);
    endtask

    task automatic check_readout(input readout_t got);
        readout_t want;
        if (pending_readouts.size() == 0)
        begin
            report_mismatch("unexpected readout", got, 0);
        end
        else
        begin
            want = pending_readouts.pop_front();
            if (got.pixel_out !== want.pixel_out)
                report_mismatch("pixel_out", got.pixel_out, want.pixel_out);
            if (got.byte_out !== want.byte_out)
                report_mismatch("byte_out", got.byte_out, want.byte_out);
            if (got.ignored !== want.ignored)
                report_mismatch("ignored", got.ignored, want.ignored);
        end
        n_checked++;
    endtask

    task automatic queue_cmd(input blit_cmd_t c, input logic typed = 1'b0,
                             input readout_t want = '0);
        stim_t s;
        while (cmd_queue.size() > 1)
            @(posedge clk);
        if (c.operation == OP_LOAD_FONT && c.font_address < FONT_BYTES)
            glyph_loaded[c.font_address] = 1'b1;
        s.cmd = c;
        s.typed = typed;
        s.want = want;
        cmd_queue.push_back(s);
    endtask

    // Load whatever bytes of the glyph are still unwritten, then draw it
    task automatic queue_draw();
        blit_cmd_t c;
        int idx;
        int per;
        int base;
        idx = $urandom_range(0, 255);
        per = (glyph_w * glyph_h + 7) / 8;
        base = idx * per;
        for (int a = base; a < base + per && a < FONT_BYTES; a++)
        begin
            if (!glyph_loaded[a])
            begin
                c = random_cmd(OP_LOAD_FONT);
                c.font_address = 13'(a);
                queue_cmd(c);
            end
        end
        c = random_cmd(OP_DRAW_CHAR);
        c.glyph_index = 8'(idx);
        c.pos_x = pick_x();
        c.pos_y = pick_y();
        queue_cmd(c);
    endtask

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || sending || pending_readouts.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input int bw, input int bh, input int gw, input int gh);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_BITMAP_WIDTH;
        cfg_data <= 8'(bw);
        @(posedge clk);
        cfg_index <= CFG_BITMAP_HEIGHT;
        cfg_data <= 8'(bh);
        @(posedge clk);
        cfg_index <= CFG_GLYPH_WIDTH;
        cfg_data <= 8'(gw);
        @(posedge clk);
        cfg_index <= CFG_GLYPH_HEIGHT;
        cfg_data <= 8'(gh);
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_w = bw & 8'hFF;
        frame_h = bh & 8'hFF;
        glyph_w = gw & 5'h1F;
        glyph_h = gh & 5'h1F;
        n_settings++;
        @(posedge clk);
    endtask

    task automatic run_phase(input int bw, input int bh, input int gw, input int gh,
                             input int count, input int draw_pct, input int hold_at);
        blit_cmd_t c;
        int kind;
        apply_settings(bw, bh, gw, gh);
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n == hold_at)
                hold_request = 300;
            kind = $urandom_range(0, 99);
            if (kind < 3)
            begin
                queue_cmd(random_cmd(OP_CLEAR));
            end
            else if (kind < 3 + draw_pct)
            begin
                queue_draw();
            end
            else if (kind < 11 + draw_pct)
            begin
                queue_cmd(random_cmd(OP_LOAD_FONT));
            end
            else if (kind < 13 + draw_pct)
            begin
                queue_cmd(random_cmd(OP_UNUSED));
            end
            else
            begin
                c = random_cmd(PIXEL_OPS[$urandom_range(0, 3)]);
                c.pos_x = pick_x();
                c.pos_y = pick_y();
                c.byte_address = pick_byte_addr();
                queue_cmd(c);
            end
        end
    endtask

    // Item sender
    initial
    begin
        stim_t    s;
        readout_t predicted;
        int       gap;
        item_ch.valid        <= 1'b0;
        item_ch.operation    <= OP_CLEAR;
        item_ch.pos_x        <= '0;
        item_ch.pos_y        <= '0;
        item_ch.pixel_value  <= 1'b0;
        item_ch.glyph_index  <= '0;
        item_ch.font_address <= '0;
        item_ch.font_byte    <= '0;
        item_ch.byte_address <= '0;
        @(posedge clk);
        forever
        begin
            if (cmd_queue.size() == 0)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                s = cmd_queue.pop_front();
                sending = 1'b1;
                gap = steady ? 0 : $urandom_range(0, 8);
                if (gap > 0)
                begin
                    item_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                item_ch.valid        <= 1'b1;
                item_ch.operation    <= s.cmd.operation;
                item_ch.pos_x        <= s.cmd.pos_x;
                item_ch.pos_y        <= s.cmd.pos_y;
                item_ch.pixel_value  <= s.cmd.pixel_value;
                item_ch.glyph_index  <= s.cmd.glyph_index;
                item_ch.font_address <= s.cmd.font_address;
                item_ch.font_byte    <= s.cmd.font_byte;
                item_ch.byte_address <= s.cmd.byte_address;
                do @(posedge clk); while (item_ch.ready !== 1'b1);
                predicted = predict_readout(s.cmd);
                pending_readouts.push_back(s.typed ? s.want : predicted);
                n_items++;
                if (s.cmd.operation == OP_DRAW_CHAR)
                    n_draws++;
                if (predicted.ignored)
                    n_flagged++;
                sending = 1'b0;
            end
        end
    end

    // Readout receiver; a hold request stalls it for a long stretch
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            check_readout('{result_ch.pixel_out, result_ch.byte_out, result_ch.ignored});
        end
    end

    initial
    begin
        #40_000_000;
        $display("Timeout: %0d readouts still expected", pending_readouts.size());
        $display("mono_bitmap_glyph_blitter_top_tb failed");
        $finish;
    end

    initial
    begin
        blit_cmd_t c;
        readout_t  want;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_mem[i] = 8'h00;
        for (int i = 0; i < FONT_BYTES; i++)
            font_mem[i] = 8'h00;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BITMAP_WIDTH;
        cfg_data  <= 8'h00;

        // op, x, y, val, gidx, addr, data, typed, pix, byte, ign
        directed_rows = '{
            '{OP_GET,        0,   0, 0, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_READ_BYTE,  0,   0, 0, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_SET,       15,   7, 1, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_GET,       15,   7, 0, 0,    0, 8'h00, 1, 1, 8'h00, 0},
            '{OP_READ_BYTE,  0,   0, 0, 0,   15, 8'h00, 1, 0, 8'h80, 0},
            '{OP_INVERT,    15,   7, 0, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_GET,       15,   7, 0, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_SET,       16,   0, 1, 0,    0, 8'h00, 1, 0, 8'h00, 1},
            '{OP_GET,        0,   8, 0, 0,    0, 8'h00, 1, 0, 8'h00, 1},
            '{OP_INVERT,   255, 255, 0, 0,    0, 8'h00, 1, 0, 8'h00, 1},
            '{OP_UNUSED,     0,   0, 0, 0,    0, 8'h00, 1, 0, 8'h00, 1},
            '{OP_READ_BYTE,  0,   0, 0, 0,  511, 8'h00, 1, 0, 8'h00, 0},
            '{OP_SET,        0,   0, 1, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_INVERT,     1,   0, 0, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_READ_BYTE,  0,   0, 0, 0,    0, 8'h00, 1, 0, 8'h03, 0},
            '{OP_LOAD_FONT,  0,   0, 0, 0,    0, 8'hFF, 1, 0, 8'h00, 0},
            '{OP_LOAD_FONT,  0,   0, 0, 0,    1, 8'h00, 1, 0, 8'h00, 0},
            '{OP_LOAD_FONT,  0,   0, 0, 0,    2, 8'hA5, 1, 0, 8'h00, 0},
            '{OP_LOAD_FONT,  0,   0, 0, 0,    3, 8'h5A, 1, 0, 8'h00, 0},
            '{OP_LOAD_FONT,  0,   0, 0, 0,    4, 8'hF0, 1, 0, 8'h00, 0},
            '{OP_LOAD_FONT,  0,   0, 0, 0, 8191, 8'h81, 1, 0, 8'h00, 0},
            '{OP_DRAW_CHAR,  0,   0, 0, 0,    0, 8'h00, 0, 0, 8'h00, 0},
            '{OP_READ_BYTE,  0,   0, 0, 0,    0, 8'h00, 0, 0, 8'h00, 0},
            '{OP_DRAW_CHAR, 13,   4, 0, 0,    0, 8'h00, 0, 0, 8'h00, 0},
            '{OP_CLEAR,      0,   0, 0, 0,    0, 8'h00, 1, 0, 8'h00, 0},
            '{OP_READ_BYTE,  0,   0, 0, 0,   16, 8'h00, 1, 0, 8'h00, 0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Default settings; glyph 0 is the only glyph drawn here
        foreach (directed_rows[i])
        begin
            c = random_cmd(directed_rows[i].op);
            c.pos_x        = directed_rows[i].x;
            c.pos_y        = directed_rows[i].y;
            c.pixel_value  = directed_rows[i].val;
            c.glyph_index  = directed_rows[i].gidx;
            c.font_address = directed_rows[i].addr;
            c.font_byte    = directed_rows[i].data;
            c.byte_address = directed_rows[i].addr[8:0];
            want = '{directed_rows[i].want_pix, directed_rows[i].want_byte,
                     directed_rows[i].want_ign};
            queue_cmd(c, directed_rows[i].typed, want);
        end

        // draws also queue glyph loads, so the item total runs above these counts
        run_phase(16, 8, 5, 8, 70, 10, 30);
        run_phase(255, 255, 16, 16, 40, 6, -1);
        run_phase(1, 1, 1, 1, 40, 15, -1);
        run_phase(255, 1, 8, 1, 40, 12, -1);
        run_phase(1, 255, 1, 16, 40, 12, -1);
        // zero glyph sizes: draws touch nothing
        run_phase(16, 8, 0, 8, 30, 30, -1);
        run_phase(40, 30, 8, 0, 20, 30, -1);
        repeat (4)
            run_phase($urandom_range(1, 255), $urandom_range(1, 255),
                      $urandom_range(1, 8), $urandom_range(1, 8), 45, 10, -1);
        run_phase(16, 8, 5, 8, 40, 10, 20);

        wait_idle();
        repeat (30) @(posedge clk);

        $display("Covered %0d items over %0d register settings, %0d of them glyph draws.",
                 n_items, n_settings, n_draws);
        $display("%0d items fell outside the stores or used the spare code; %0d readouts checked.",
                 n_flagged, n_checked);
        if (n_errors == 0)
            $display("mono_bitmap_glyph_blitter_top_tb passed");
        else
            $display("mono_bitmap_glyph_blitter_top_tb failed");
        $finish;
    end

endmodule
